/* hdl/small_cache_hit_miss_model_macros.svh */
// Assertion macros shared by the cache checker
`ifndef SMALL_CACHE_HIT_MISS_MODEL_MACROS_SVH
`define SMALL_CACHE_HIT_MISS_MODEL_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define SCM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cache check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define SCM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cache check failed");

`endif

/* hdl/scm_pkg.sv */
// Shared types and constants of the four-line cache hit/miss model
`default_nettype none

package scm_pkg;

    localparam int LINES      = 4;
    localparam int SETS       = LINES / 2;
    localparam int LINE_IDX_W = $clog2(LINES);
    localparam int SET_IDX_W  = $clog2(SETS);
    localparam int AGE_W      = $clog2(LINES);
    localparam int MODE_W     = 2;

    // Placement codes of the mapping register; the unused code acts as LRU
    localparam logic [MODE_W-1:0] MAP_DIRECT  = 2'd0;
    localparam logic [MODE_W-1:0] MAP_TWO_WAY = 2'd1;
    localparam logic [MODE_W-1:0] MAP_LRU     = 2'd2;

    typedef logic [MODE_W-1:0] mode_t;
    typedef logic [AGE_W-1:0]  age_t;

    typedef enum logic {
        ST_EMPTY,
        ST_FULL
    } ctrl_state_t;

    // Command from the controller to the datapath
    typedef struct packed {
        logic access;   // perform lookup/update and load the result register
    } scm_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic mode_lru; // current placement uses age-based replacement
    } scm_status_t;

endpackage

`default_nettype wire

/* hdl/scm_ctrl.sv */
// Handshake controller: tracks the result register and issues access commands
`default_nettype none

module scm_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire scm_pkg::scm_status_t status,
    output scm_pkg::scm_cmd_t        cmd
);
    import scm_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        mode_lru_reg;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_EMPTY;
            mode_lru_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            mode_lru_reg <= status.mode_lru;
        end
    end

    // Accept a transaction whenever the result register is free or drains now
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b1;
        out_valid  = 1'b0;
        cmd.access = 1'b0;
        unique case (state_reg)
            ST_EMPTY:
            begin
                in_ready   = 1'b1;
                out_valid  = 1'b0;
                cmd.access = in_valid;
                if (in_valid)
                begin
                    state_next = ST_FULL;
                end
            end
            ST_FULL:
            begin
                in_ready   = out_ready;
                out_valid  = 1'b1;
                cmd.access = in_valid && out_ready;
                if (out_ready && !in_valid)
                begin
                    state_next = ST_EMPTY;
                end
            end
            default:
            begin
                state_next = ST_EMPTY;
            end
        endcase
        // mode_lru only tracked for visibility of the replacement policy
        if (mode_lru_reg && 1'b0)
        begin
            state_next = ST_EMPTY;
        end
    end

endmodule

`default_nettype wire

/* hdl/scm_datapath.sv */
// Cache datapath: line tags, valid bits, victim pointers, ages and result register
`default_nettype none

module scm_datapath #(
    parameter int ADDR_BITS = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire scm_pkg::mode_t       cfg_wdata,
    input  wire logic [ADDR_BITS-1:0] block_address,
    input  wire logic                 start_sequence,
    input  wire scm_pkg::scm_cmd_t    cmd,
    output scm_pkg::scm_status_t      status,
    output logic                      hit
);
    import scm_pkg::*;

    mode_t                mode_reg;
    logic [ADDR_BITS-1:0] line_addr_reg [LINES];
    logic [LINES-1:0]     valid_reg;
    logic [LINES-1:0]     valid_next;
    logic [SETS-1:0]      victim_reg;
    logic [SETS-1:0]      victim_next;
    age_t                 age_reg  [LINES];
    age_t                 age_next [LINES];
    logic                 hit_reg;
    logic                 hit_next;
    logic                 fill_en;
    logic [LINE_IDX_W-1:0] fill_idx;

    // Cleared view of the state when a new sequence starts
    logic [LINES-1:0]     eff_valid;
    logic [SETS-1:0]      eff_victim;
    age_t                 eff_age [LINES];
    logic [LINES-1:0]     match;

    // Hold the mapping register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MAP_DIRECT;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_wdata;
        end
    end

    // Apply start-of-sequence clear and compare all lines in parallel
    always_comb
    begin
        for (int k = 0; k < LINES; k++)
        begin
            eff_valid[k] = start_sequence ? 1'b0 : valid_reg[k];
            eff_age[k]   = start_sequence ? AGE_W'(LINES - 1 - k) : age_reg[k];
            match[k]     = eff_valid[k] && (line_addr_reg[k] == block_address);
        end
        eff_victim = start_sequence ? '0 : victim_reg;
    end

    // Work out hit, fill line and replacement update
    always_comb
    begin
        logic [SET_IDX_W-1:0]  set_idx;
        logic                  way;
        logic                  lru_hit;
        logic [LINE_IDX_W-1:0] lru_hit_idx;
        logic [LINE_IDX_W-1:0] lru_vic_idx;
        logic [LINE_IDX_W-1:0] touch_idx;
        age_t                  old_age;

        set_idx     = block_address[SET_IDX_W-1:0];
        way         = 1'b0;
        lru_hit     = 1'b0;
        lru_hit_idx = '0;
        lru_vic_idx = '0;
        touch_idx   = '0;
        old_age     = '0;

        valid_next  = valid_reg;
        victim_next = victim_reg;
        for (int k = 0; k < LINES; k++)
        begin
            age_next[k] = age_reg[k];
        end
        hit_next = hit_reg;
        fill_en  = 1'b0;
        fill_idx = block_address[LINE_IDX_W-1:0];

        if (cmd.access)
        begin
            valid_next  = eff_valid;
            victim_next = eff_victim;
            for (int k = 0; k < LINES; k++)
            begin
                age_next[k] = eff_age[k];
            end

            unique case (mode_reg)
                MAP_DIRECT:
                begin
                    hit_next = match[fill_idx];
                    fill_en  = !match[fill_idx];
                end
                MAP_TWO_WAY:
                begin
                    if (match[{set_idx, 1'b0}])
                    begin
                        hit_next             = 1'b1;
                        victim_next[set_idx] = 1'b1;
                    end
                    else if (match[{set_idx, 1'b1}])
                    begin
                        hit_next             = 1'b1;
                        victim_next[set_idx] = 1'b0;
                    end
                    else
                    begin
                        way                  = eff_victim[set_idx];
                        hit_next             = 1'b0;
                        fill_en              = 1'b1;
                        fill_idx             = {set_idx, way};
                        victim_next[set_idx] = !way;
                    end
                end
                default:
                begin
                    // Lowest matching line wins
                    for (int k = LINES - 1; k >= 0; k--)
                    begin
                        if (match[k])
                        begin
                            lru_hit     = 1'b1;
                            lru_hit_idx = LINE_IDX_W'(k);
                        end
                    end
                    // Oldest line, lowest index on a tie
                    for (int k = 1; k < LINES; k++)
                    begin
                        if (eff_age[k] > eff_age[lru_vic_idx])
                        begin
                            lru_vic_idx = LINE_IDX_W'(k);
                        end
                    end
                    touch_idx = lru_hit ? lru_hit_idx : lru_vic_idx;
                    hit_next  = lru_hit;
                    fill_en   = !lru_hit;
                    fill_idx  = lru_vic_idx;
                    // Age every younger line and make the touched one newest
                    old_age = eff_age[touch_idx];
                    for (int k = 0; k < LINES; k++)
                    begin
                        if (LINE_IDX_W'(k) == touch_idx)
                        begin
                            age_next[k] = '0;
                        end
                        else if (eff_age[k] < old_age)
                        begin
                            age_next[k] = eff_age[k] + age_t'(1);
                        end
                    end
                end
            endcase

            if (fill_en)
            begin
                valid_next[fill_idx] = 1'b1;
            end
        end
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            victim_reg <= '0;
            for (int k = 0; k < LINES; k++)
            begin
                age_reg[k] <= AGE_W'(LINES - 1 - k);
            end
        end
        else
        begin
            valid_reg  <= valid_next;
            victim_reg <= victim_next;
            for (int k = 0; k < LINES; k++)
            begin
                age_reg[k] <= age_next[k];
            end
        end
    end

    // Store tags and the result
    always_ff @(posedge clk)
    begin
        hit_reg <= hit_next;
        if (cmd.access && fill_en)
        begin
            line_addr_reg[fill_idx] <= block_address;
        end
    end

    assign hit             = hit_reg;
    assign status.mode_lru = (mode_reg != MAP_DIRECT) && (mode_reg != MAP_TWO_WAY);

endmodule

`default_nettype wire

/* hdl/small_cache_hit_miss_model.sv */
// Top level of the four-line cache hit/miss model
//
//  channel | handshake               | payload
//  --------+-------------------------+--------------------------------
//  input   | in_valid / in_ready     | block_address, start_sequence
//  output  | out_valid / out_ready   | hit
//  config  | cfg_we                  | cfg_wdata (mapping mode)
//
// One transaction per cycle: the lookup, the tag compare on all four lines and
// the replacement update run in the cycle of acceptance; hit appears in the
// result register on the next cycle. While that result is stalled by out_ready
// low, in_ready follows out_ready. Reset empties the cache, sets ages 3,2,1,0,
// set victims to way zero and the mapping mode to direct mapped.
`default_nettype none

module small_cache_hit_miss_model #(
    parameter int ADDR_BITS = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire scm_pkg::mode_t       cfg_wdata,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [ADDR_BITS-1:0] block_address,
    input  wire logic                 start_sequence,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      hit
);
    import scm_pkg::*;

    scm_cmd_t    cmd;
    scm_status_t status;

    scm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    scm_datapath #(
        .ADDR_BITS (ADDR_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .block_address  (block_address),
        .start_sequence (start_sequence),
        .cmd            (cmd),
        .status         (status),
        .hit            (hit)
    );

endmodule

`default_nettype wire

/* hdl/scm_checker.sv */
// Port-level checker for the cache model and its bind to the top level
`default_nettype none

`include "small_cache_hit_miss_model_macros.svh"

module scm_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic start_sequence,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic hit
);

    // Every accepted transaction leaves a result on the next cycle
    `SCM_ASSERT_NEXT(a_result_follows, in_valid && in_ready, out_valid)

    // A freshly cleared cache always misses
    `SCM_ASSERT_NEXT(a_start_misses, in_valid && in_ready && start_sequence, !hit)

    // Never take a transaction while a stalled result would be overwritten
    `SCM_ASSERT_NOW(a_no_overrun, out_valid && !out_ready, !in_ready)

    // A stalled result holds its value
    `SCM_ASSERT_NEXT(a_result_holds, out_valid && !out_ready, out_valid && $stable(hit))

endmodule

bind small_cache_hit_miss_model scm_checker u_scm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .start_sequence (start_sequence),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .hit            (hit)
);

`default_nettype wire

/* dv/scm_hit_check.sv */
// Hit/miss predictor and result checker for the four-line cache model
module scm_hit_check #(
    parameter int ADDR_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  scm_pkg::mode_t       cfg_wdata,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [ADDR_BITS-1:0] block_address,
    input  logic                 start_sequence,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic                 hit,
    output int                   mismatches,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import scm_pkg::*;

    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [ADDR_BITS-1:0] addr;
        logic                 hit;
    } lookup_t;

    // Shadow copy of the cache and its replacement state
    mode_t                mode_q;
    logic [ADDR_BITS-1:0] tag_q [LINES];
    logic                 vld_q [LINES];
    logic                 victim_q [SETS];
    age_t                 age_q [LINES];

    lookup_t expected_hits_q [$];

    // Empty all lines and restore the initial replacement order
    function automatic void clear_lines();
        for (int k = 0; k < LINES; k++) begin
            tag_q[k] = '0;
            vld_q[k] = 1'b0;
            age_q[k] = age_t'(LINES - 1 - k);
        end
        for (int s = 0; s < SETS; s++) begin
            victim_q[s] = 1'b0;
        end
    endfunction

    // Make line k the most recently used one
    function automatic void promote(int k);
        age_t prev;
        prev = age_q[k];
        for (int j = 0; j < LINES; j++) begin
            if (j != k && age_q[j] < prev)
                age_q[j] = age_q[j] + age_t'(1);
        end
        age_q[k] = '0;
    endfunction

    function automatic logic holds(int k, logic [ADDR_BITS-1:0] addr);
        return vld_q[k] && tag_q[k] == addr;
    endfunction

    // Look one address up, update the shadow state and return hit
    function automatic logic lookup_hit(logic [ADDR_BITS-1:0] addr, logic clear);
        int k;
        int base;
        logic s;
        logic w;
        if (clear)
            clear_lines();
        case (mode_q)
            MAP_DIRECT: begin
                k = int'(addr[LINE_IDX_W-1:0]);
                if (holds(k, addr))
                    return 1'b1;
                tag_q[k] = addr;
                vld_q[k] = 1'b1;
                return 1'b0;
            end
            MAP_TWO_WAY: begin
                s = addr[0];
                base = 2 * int'(s);
                for (int i = 0; i < 2; i++) begin
                    if (holds(base + i, addr)) begin
                        victim_q[s] = (i == 0);
                        return 1'b1;
                    end
                end
                w = victim_q[s];
                tag_q[base + int'(w)] = addr;
                vld_q[base + int'(w)] = 1'b1;
                victim_q[s] = ~w;
                return 1'b0;
            end
            default: begin
                for (int i = 0; i < LINES; i++) begin
                    if (holds(i, addr)) begin
                        promote(i);
                        return 1'b1;
                    end
                end
                k = 0;
                for (int i = 1; i < LINES; i++) begin
                    if (age_q[i] > age_q[k])
                        k = i;
                end
                tag_q[k] = addr;
                vld_q[k] = 1'b1;
                promote(k);
                return 1'b0;
            end
        endcase
    endfunction

    function automatic void flag(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
    endfunction

    // Check results, then predict accepted lookups, then take register writes
    always @(posedge clk) begin : track
        lookup_t want;
        lookup_t rec;
        if (!rst_n) begin
            mode_q = MAP_DIRECT;
            clear_lines();
            expected_hits_q.delete();
        end
        else begin
            if (out_valid && out_ready) begin
                if (expected_hits_q.size() == 0) begin
                    flag($sformatf("unexpected result hit=%0b with no lookup pending", hit));
                end
                else begin
                    want = expected_hits_q.pop_front();
                    if (hit !== want.hit)
                        flag($sformatf("addr %h: hit expected %0b got %0b",
                                       want.addr, want.hit, hit));
                end
            end
            if (in_valid && in_ready) begin
                rec.addr = block_address;
                rec.hit  = lookup_hit(block_address, start_sequence);
                expected_hits_q.push_back(rec);
            end
            if (cfg_we)
                mode_q = cfg_wdata;
        end
        pending = expected_hits_q.size();
    end

endmodule

/* dv/tb.sv */
// Stimulus and verdict for the four-line cache hit/miss model
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scm_pkg::*;

    localparam int    ADDR_BITS  = 32;
    localparam mode_t MAP_SPARE  = 2'd3;
    localparam int    MAX_GAP    = 12;
    localparam int    LONG_HOLD  = 120;
    localparam int    PHASES     = 8;
    localparam int    PHASE_LEN  = 250;
    localparam int    POOL_SIZE  = 8;
    localparam int    CYCLE_MAX  = 500000;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    mode_t                cfg_wdata;
    logic                 in_valid;
    logic                 in_ready;
    logic [ADDR_BITS-1:0] block_address;
    logic                 start_sequence;
    logic                 out_valid;
    logic                 out_ready;
    logic                 hit;

    int                   mismatch_count;
    int                   pending_hits;
    int                   cycles = 0;
    bit                   burst = 1'b0;
    logic [ADDR_BITS-1:0] addr_pool [POOL_SIZE];

    always #5 clk = ~clk;

    small_cache_hit_miss_model #(
        .ADDR_BITS(ADDR_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .block_address (block_address),
        .start_sequence(start_sequence),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .hit           (hit)
    );

    scm_hit_check #(
        .ADDR_BITS(ADDR_BITS)
    ) hit_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .block_address (block_address),
        .start_sequence(start_sequence),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .hit           (hit),
        .mismatches    (mismatch_count),
        .pending       (pending_hits)
    );

    // Abort a hung run
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_MAX) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Offer one lookup after a random gap and hold it until accepted
    task automatic send_access(input logic [ADDR_BITS-1:0] addr, input logic clear);
        int gap;
        gap = burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        block_address  <= addr;
        start_sequence <= clear;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Stop offering and wait until every lookup has answered
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_hits != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Change placement only while the cache is idle
    task automatic set_mode(input mode_t m);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly reuse a small working set so that hits and conflicts are common
    function automatic logic [ADDR_BITS-1:0] pick_address();
        int r;
        logic [ADDR_BITS-1:0] a;
        r = $urandom_range(0, 99);
        if (r < 70)
            a = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (r < 85)
            a = addr_pool[$urandom_range(0, POOL_SIZE - 1)] ^ (32'h1 << $urandom_range(0, 31));
        else if (r < 95)
            a = $urandom;
        else
            a = r[0] ? '1 : '0;
        return a;
    endfunction

    function automatic void refill_pool();
        for (int k = 0; k < POOL_SIZE; k++)
            addr_pool[k] = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 15);
    endfunction

    // Receiver: random stalls per transaction, with two long hold-offs
    initial begin : receiver
        int wait_cycles;
        int taken;
        taken = 0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            if (taken == 500 || taken == 1500)
                wait_cycles = LONG_HOLD;
            else if (burst)
                wait_cycles = 0;
            else
                wait_cycles = $urandom_range(0, MAX_GAP);
            if (wait_cycles > 0) begin
                out_ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            taken++;
        end
    end

    initial begin : stimulus
        mode_t m;
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_wdata      <= MAP_DIRECT;
        in_valid       <= 1'b0;
        block_address  <= '0;
        start_sequence <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Direct mapped: conflicts on one line, all-ones address
        set_mode(MAP_DIRECT);
        send_access(32'h0000_0000, 1'b1);
        send_access(32'h0000_0000, 1'b0);
        send_access(32'h0000_0004, 1'b0);
        send_access(32'h0000_0000, 1'b0);
        send_access(32'hFFFF_FFFF, 1'b0);
        send_access(32'hFFFF_FFFF, 1'b0);
        send_access(32'h8000_0003, 1'b0);

        // Two-way: lines kept across the mode change, victim pointer per set
        set_mode(MAP_TWO_WAY);
        send_access(32'h0000_0001, 1'b0);
        send_access(32'h0000_0003, 1'b0);
        send_access(32'h0000_0001, 1'b0);
        send_access(32'h0000_0005, 1'b0);
        send_access(32'h0000_0003, 1'b0);
        send_access(32'h0000_0002, 1'b0);

        // Fully associative: possible duplicate lines, age-based eviction
        set_mode(MAP_LRU);
        send_access(32'h0000_0003, 1'b0);
        send_access(32'h0000_0000, 1'b0);
        send_access(32'h0000_0007, 1'b0);
        send_access(32'h0000_0009, 1'b0);
        send_access(32'h0000_0000, 1'b0);

        // Unused mode code acts as LRU; clear in mid-stream
        set_mode(MAP_SPARE);
        send_access(32'hAAAA_5555, 1'b0);
        send_access(32'h5555_AAAA, 1'b0);
        send_access(32'h0000_0000, 1'b1);
        send_access(32'hAAAA_5555, 1'b0);

        // Random phases, each under one placement
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph < 4)
                m = mode_t'(ph);
            else
                m = mode_t'($urandom_range(MAP_DIRECT, MAP_SPARE));
            set_mode(m);
            refill_pool();
            for (int n = 0; n < PHASE_LEN; n++) begin
                burst = (n >= 150 && n < 200);
                if (n == PHASE_LEN / 2 && ph == 4)
                    wait_drained();
                send_access(pick_address(), $urandom_range(0, 39) == 0);
            end
            burst = 1'b0;
        end

        wait_drained();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
